// ----- design/rmsd_pkg.sv -----
package rmsd_pkg;

  // field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WAIT_W     = 16;
  localparam int unsigned ROW_IDX_W  = 4;
  localparam int unsigned ADDR_PIN_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  // default geometry
  localparam int unsigned SCAN_ROWS_DEF = 8;
  localparam int unsigned COLUMNS_DEF   = 32;

  // register reset values
  localparam logic [WAIT_W-1:0] CLOCK_WAIT_RST  = 16'd10;
  localparam logic [WAIT_W-1:0] ENABLE_WAIT_RST = 16'd500;

  // operation codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_WAIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_WAIT = 2'd1;

  // one panel row, all three colours
  typedef struct packed {
    logic [DATA_W-1:0] red;
    logic [DATA_W-1:0] green;
    logic [DATA_W-1:0] blue;
  } pixel_word_t;

  // panel pin levels
  typedef struct packed {
    logic [ADDR_PIN_W-1:0] addr;
    logic                  clk;
    logic                  stb;
    logic                  oe_n;
    logic                  ru;
    logic                  rl;
    logic                  gu;
    logic                  gl;
    logic                  bu;
    logic                  bl;
  } pins_t;

  // scan sequencer phases
  typedef enum logic [2:0] {
    PH_ADDR     = 3'd0,
    PH_DATA     = 3'd1,
    PH_CLK_LOW  = 3'd2,
    PH_CLK_HIGH = 3'd3,
    PH_STB_HIGH = 3'd4,
    PH_STB_LOW  = 3'd5,
    PH_OE_LOW   = 3'd6,
    PH_OE_HIGH  = 3'd7
  } phase_t;

endpackage

// ----- design/rmsd_frame_store.sv -----
module rmsd_frame_store #(
  parameter int unsigned DEPTH = rmsd_pkg::SCAN_ROWS_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  rmsd_pkg::pixel_word_t wdata,
  input  logic [AW-1:0]        raddr,
  output rmsd_pkg::pixel_word_t rdata
);
  import rmsd_pkg::*;

  pixel_word_t      mem [DEPTH];
  pixel_word_t      rd_r;
  pixel_word_t      wdata_r;
  logic [DEPTH-1:0] valid_r;
  logic             rd_ok_r;
  logic             fwd_r;

  // row storage with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r    <= mem[raddr];
    wdata_r <= wdata;
  end

  // per-row valid bits give the cleared frame after reset; bypass on same-row write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rd_ok_r <= valid_r[raddr];
      fwd_r   <= we && (waddr == raddr);
    end
  end

  always_comb begin
    if (fwd_r) begin
      rdata = wdata_r;
    end else if (rd_ok_r) begin
      rdata = rd_r;
    end else begin
      rdata = '0;
    end
  end

endmodule

// ----- design/rmsd_sequencer.sv -----
module rmsd_sequencer #(
  parameter int unsigned SCAN_ROWS = rmsd_pkg::SCAN_ROWS_DEF,
  parameter int unsigned COLUMNS   = rmsd_pkg::COLUMNS_DEF,
  localparam int unsigned RW = $clog2(SCAN_ROWS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick,
  input  logic [rmsd_pkg::WAIT_W-1:0]  clock_wait,
  input  logic [rmsd_pkg::WAIT_W-1:0]  enable_wait,
  input  rmsd_pkg::pixel_word_t        upper_word,
  input  rmsd_pkg::pixel_word_t        lower_word,
  output logic [RW-1:0]                scan_row_nxt,
  output rmsd_pkg::pins_t              pins_nxt,
  output logic                         done
);
  import rmsd_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS);

  phase_t              phase_r, phase_nxt;
  logic [RW-1:0]       scan_row_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;
  pins_t               pins_r;
  logic [6:0]          bit_idx;
  logic                bit_ok;
  logic                wait_busy;

  // column to word bit, first column is the top bit; columns past the word read zero
  assign bit_idx   = 7'(COLUMNS - 1) - 7'(col_r);
  assign bit_ok    = bit_idx < 7'd32;
  assign wait_busy = wait_r != '0;

  // next phase and pin levels
  always_comb begin
    phase_nxt    = phase_r;
    scan_row_nxt = scan_row_r;
    col_nxt      = col_r;
    wait_nxt     = wait_r;
    pins_nxt     = pins_r;
    done         = 1'b0;
    if (tick) begin
      unique case (phase_r)
        PH_ADDR: begin
          pins_nxt.addr = ADDR_PIN_W'(scan_row_r);
          col_nxt       = '0;
          phase_nxt     = PH_DATA;
        end
        PH_DATA: begin
          pins_nxt.ru = bit_ok & upper_word.red[bit_idx[4:0]];
          pins_nxt.rl = bit_ok & lower_word.red[bit_idx[4:0]];
          pins_nxt.gu = bit_ok & upper_word.green[bit_idx[4:0]];
          pins_nxt.gl = bit_ok & lower_word.green[bit_idx[4:0]];
          pins_nxt.bu = bit_ok & upper_word.blue[bit_idx[4:0]];
          pins_nxt.bl = bit_ok & lower_word.blue[bit_idx[4:0]];
          wait_nxt    = clock_wait;
          phase_nxt   = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          if (wait_busy) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            pins_nxt.clk = 1'b0;
            wait_nxt     = clock_wait;
            phase_nxt    = PH_CLK_HIGH;
          end
        end
        PH_CLK_HIGH: begin
          if (wait_busy) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            pins_nxt.clk = 1'b1;
            if (col_r == CW'(COLUMNS - 1)) begin
              phase_nxt = PH_STB_HIGH;
            end else begin
              col_nxt   = col_r + 1'b1;
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_STB_HIGH: begin
          pins_nxt.stb = 1'b1;
          wait_nxt     = clock_wait;
          phase_nxt    = PH_STB_LOW;
        end
        PH_STB_LOW: begin
          if (wait_busy) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            pins_nxt.stb = 1'b0;
            wait_nxt     = clock_wait;
            phase_nxt    = PH_OE_LOW;
          end
        end
        PH_OE_LOW: begin
          if (wait_busy) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            pins_nxt.oe_n = 1'b0;
            wait_nxt      = enable_wait;
            phase_nxt     = PH_OE_HIGH;
          end
        end
        PH_OE_HIGH: begin
          if (wait_busy) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            pins_nxt.oe_n = 1'b1;
            if (scan_row_r == RW'(SCAN_ROWS - 1)) begin
              scan_row_nxt = '0;
              done         = 1'b1;
            end else begin
              scan_row_nxt = scan_row_r + 1'b1;
            end
            phase_nxt = PH_ADDR;
          end
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ADDR;
      scan_row_r <= '0;
      col_r      <= '0;
      wait_r     <= '0;
      pins_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      scan_row_r <= scan_row_nxt;
      col_r      <= col_nxt;
      wait_r     <= wait_nxt;
      pins_r     <= pins_nxt;
    end
  end

  // end of frame always restarts at the first scan row
  a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (scan_row_r == '0) && (phase_r == PH_ADDR))
    else $error("frame end did not restart the scan");

  // strobe is only high while its hold phase runs
  a_stb_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pins_r.stb |-> (phase_r == PH_STB_LOW))
    else $error("strobe high outside its window");

  // LEDs switch on only as the enable window opens
  a_oe_on: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pins_r.oe_n) |-> (phase_r == PH_OE_HIGH))
    else $error("LEDs enabled outside the enable window");

endmodule

// ----- design/rgb_matrix_scan_driver.sv -----
// Scan driver for a 16x32 one-bit RGB panel with 1/8 scan. Store words write a panel row
// into the frame store; tick words step the pin sequencer by one tick; every accepted word
// returns one result word with the pin levels after it. One word is accepted per clock
// cycle while the result side does not stall; a result passes the input register, then the
// result register behind the sequencer logic. The frame store reads as zero after reset
// through per-row valid bits, so no clearing pass is run. With clock_wait = W one column
// takes 2W+3 ticks, and one scan row takes COLUMNS*(2W+3) + 2W + enable_wait + 5 ticks.
module rgb_matrix_scan_driver #(
  parameter int unsigned SCAN_ROWS = rmsd_pkg::SCAN_ROWS_DEF,
  parameter int unsigned COLUMNS   = rmsd_pkg::COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [rmsd_pkg::ROW_IDX_W-1:0]    in_row_index,
  input  logic [rmsd_pkg::DATA_W-1:0]       in_red_bits,
  input  logic [rmsd_pkg::DATA_W-1:0]       in_green_bits,
  input  logic [rmsd_pkg::DATA_W-1:0]       in_blue_bits,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rmsd_pkg::ADDR_PIN_W-1:0]   out_row_address,
  output logic                              out_pixel_clock,
  output logic                              out_strobe_res,
  output logic                              out_output_enable_n,
  output logic                              out_red_upper,
  output logic                              out_red_lower,
  output logic                              out_green_upper,
  output logic                              out_green_lower,
  output logic                              out_blue_upper,
  output logic                              out_blue_lower,
  output logic                              out_frame_done,
  input  logic                              cfg_we,
  input  logic [rmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmsd_pkg::WAIT_W-1:0]       cfg_wdata
);
  import rmsd_pkg::*;

  localparam int unsigned RW = $clog2(SCAN_ROWS);

  logic                  in_vld_r;
  logic                  in_op_r;
  logic [ROW_IDX_W-1:0]  in_row_r;
  pixel_word_t           in_word_r;
  logic                  out_vld_r;
  pins_t                 res_pins_r;
  logic                  res_done_r;
  logic [WAIT_W-1:0]     clock_wait_r;
  logic [WAIT_W-1:0]     enable_wait_r;
  logic                  in_take;
  logic                  exec_go;
  logic                  tick;
  logic                  store;
  logic [5:0]            row_ext;
  logic                  we_upper;
  logic                  we_lower;
  logic [RW-1:0]         waddr_upper;
  logic [RW-1:0]         waddr_lower;
  logic [RW-1:0]         scan_row_nxt;
  pixel_word_t           upper_word;
  pixel_word_t           lower_word;
  pins_t                 pins_nxt;
  logic                  done;

  // handshakes: the execute stage moves whenever the result register can take a word
  assign exec_go  = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign tick     = exec_go && (in_op_r == OP_TICK);
  assign store    = exec_go && (in_op_r == OP_STORE);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take || (in_vld_r && !exec_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_operation;
      in_row_r  <= in_row_index;
      in_word_r <= '{red: in_red_bits, green: in_green_bits, blue: in_blue_bits};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_wait_r  <= CLOCK_WAIT_RST;
      enable_wait_r <= ENABLE_WAIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_CLOCK_WAIT) begin
        clock_wait_r <= cfg_wdata;
      end else if (cfg_index == REG_ENABLE_WAIT) begin
        enable_wait_r <= cfg_wdata;
      end
    end
  end

  // row decode: upper half rows then lower half rows, rows past the panel are dropped
  assign row_ext     = 6'(in_row_r);
  assign we_upper    = store && (row_ext < 6'(SCAN_ROWS));
  assign we_lower    = store && (row_ext >= 6'(SCAN_ROWS)) && (row_ext < 6'(2 * SCAN_ROWS));
  assign waddr_upper = RW'(row_ext);
  assign waddr_lower = RW'(row_ext - 6'(SCAN_ROWS));

  rmsd_frame_store #(
    .DEPTH (SCAN_ROWS)
  ) u_store_upper (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we_upper),
    .waddr (waddr_upper),
    .wdata (in_word_r),
    .raddr (scan_row_nxt),
    .rdata (upper_word)
  );

  rmsd_frame_store #(
    .DEPTH (SCAN_ROWS)
  ) u_store_lower (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we_lower),
    .waddr (waddr_lower),
    .wdata (in_word_r),
    .raddr (scan_row_nxt),
    .rdata (lower_word)
  );

  rmsd_sequencer #(
    .SCAN_ROWS (SCAN_ROWS),
    .COLUMNS   (COLUMNS)
  ) u_sequencer (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick         (tick),
    .clock_wait   (clock_wait_r),
    .enable_wait  (enable_wait_r),
    .upper_word   (upper_word),
    .lower_word   (lower_word),
    .scan_row_nxt (scan_row_nxt),
    .pins_nxt     (pins_nxt),
    .done         (done)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= exec_go || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_pins_r <= pins_nxt;
      res_done_r <= done;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_row_address     = res_pins_r.addr;
  assign out_pixel_clock     = res_pins_r.clk;
  assign out_strobe_res      = res_pins_r.stb;
  assign out_output_enable_n = res_pins_r.oe_n;
  assign out_red_upper       = res_pins_r.ru;
  assign out_red_lower       = res_pins_r.rl;
  assign out_green_upper     = res_pins_r.gu;
  assign out_green_lower     = res_pins_r.gl;
  assign out_blue_upper      = res_pins_r.bu;
  assign out_blue_lower      = res_pins_r.bl;
  assign out_frame_done      = res_done_r;

  // input side only holds off while a result is stuck downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_vld_r && in_vld_r)
    else $error("input stalled without a blocked result");

  // a word leaving the execute stage always lands in the result register
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_vld_r)
    else $error("executed word produced no result");

  // frame end is reported together with the LEDs switching off
  a_done_oe: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_done_r |-> res_pins_r.oe_n)
    else $error("frame end reported with LEDs still enabled");

  // a store never reports a frame end
  a_store_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> !res_done_r)
    else $error("store word reported a frame end");

endmodule

// ----- sim/rgb_matrix_scan_driver_tb.sv -----
`timescale 1ns / 100ps

module rgb_matrix_scan_driver_tb;
  import rmsd_pkg::*;

  localparam int unsigned SCAN_ROWS  = SCAN_ROWS_DEF;
  localparam int unsigned COLUMNS    = COLUMNS_DEF;
  localparam int unsigned PANEL_ROWS = 2 * SCAN_ROWS;
  localparam int          LIMIT      = 300000;
  localparam int          HOLD_AT    = 300;
  localparam int          HOLD_LEN   = 300;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    pins_t pins;
    logic  done;
  } pin_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_operation;
  logic [ROW_IDX_W-1:0]  in_row_index;
  logic [DATA_W-1:0]     in_red_bits;
  logic [DATA_W-1:0]     in_green_bits;
  logic [DATA_W-1:0]     in_blue_bits;
  logic                  out_valid;
  logic                  out_stall;
  logic [ADDR_PIN_W-1:0] out_row_address;
  logic                  out_pixel_clock;
  logic                  out_strobe_res;
  logic                  out_output_enable_n;
  logic                  out_red_upper;
  logic                  out_red_lower;
  logic                  out_green_upper;
  logic                  out_green_lower;
  logic                  out_blue_upper;
  logic                  out_blue_lower;
  logic                  out_frame_done;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [WAIT_W-1:0]     cfg_wdata;

  int words_accepted;
  int cycles;
  int reg_writes;
  bit long_hold_done;

  rgb_matrix_scan_driver #(
    .SCAN_ROWS(SCAN_ROWS),
    .COLUMNS  (COLUMNS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_row_index       (in_row_index),
    .in_red_bits        (in_red_bits),
    .in_green_bits      (in_green_bits),
    .in_blue_bits       (in_blue_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_row_address    (out_row_address),
    .out_pixel_clock    (out_pixel_clock),
    .out_strobe_res     (out_strobe_res),
    .out_output_enable_n(out_output_enable_n),
    .out_red_upper      (out_red_upper),
    .out_red_lower      (out_red_lower),
    .out_green_upper    (out_green_upper),
    .out_green_lower    (out_green_lower),
    .out_blue_upper     (out_blue_upper),
    .out_blue_lower     (out_blue_lower),
    .out_frame_done     (out_frame_done),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // panel sequencer model and the queue of pin levels still to come
  class pin_scoreboard;
    logic [DATA_W-1:0] red_mem   [PANEL_ROWS];
    logic [DATA_W-1:0] green_mem [PANEL_ROWS];
    logic [DATA_W-1:0] blue_mem  [PANEL_ROWS];
    logic [WAIT_W-1:0] clock_wait;
    logic [WAIT_W-1:0] enable_wait;
    logic [WAIT_W-1:0] wait_cnt;
    logic [2:0]        scan_row;
    int unsigned       column;
    phase_t            phase;
    pins_t             pins;
    pin_result_t       pending_pins[$];
    int                errors;
    int                checked;
    int                frames;
    int                ticks;
    int                stores;

    function new();
      for (int i = 0; i < PANEL_ROWS; i++) begin
        red_mem[i]   = '0;
        green_mem[i] = '0;
        blue_mem[i]  = '0;
      end
      clock_wait  = CLOCK_WAIT_RST;
      enable_wait = ENABLE_WAIT_RST;
      wait_cnt    = '0;
      scan_row    = '0;
      column      = 0;
      phase       = PH_ADDR;
      pins        = '0;
      errors      = 0;
      checked     = 0;
      frames      = 0;
      ticks       = 0;
      stores      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WAIT_W-1:0] val);
      case (idx)
        REG_CLOCK_WAIT:  clock_wait = val;
        REG_ENABLE_WAIT: enable_wait = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_pins.size();
    endfunction

    // a waiting phase only counts down while the counter is nonzero
    function bit hold_wait();
      if (wait_cnt != '0) begin
        wait_cnt = wait_cnt - 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // one tick of the scan sequencer, returns the end-of-frame flag
    function logic advance_scan();
      logic            done;
      logic [3:0]      lower_row;
      int unsigned     bit_pos;
      done      = 1'b0;
      lower_row = {1'b0, scan_row} + 4'(SCAN_ROWS);
      bit_pos   = COLUMNS - 1 - column;
      case (phase)
        PH_ADDR: begin
          pins.addr = {1'b0, scan_row};
          column    = 0;
          phase     = PH_DATA;
        end
        PH_DATA: begin
          // reads are live, so a store mid-row shows on later columns
          pins.ru  = red_mem[scan_row][bit_pos];
          pins.rl  = red_mem[lower_row][bit_pos];
          pins.gu  = green_mem[scan_row][bit_pos];
          pins.gl  = green_mem[lower_row][bit_pos];
          pins.bu  = blue_mem[scan_row][bit_pos];
          pins.bl  = blue_mem[lower_row][bit_pos];
          wait_cnt = clock_wait;
          phase    = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          if (!hold_wait()) begin
            pins.clk = 1'b0;
            wait_cnt = clock_wait;
            phase    = PH_CLK_HIGH;
          end
        end
        PH_CLK_HIGH: begin
          if (!hold_wait()) begin
            pins.clk = 1'b1;
            if (column + 1 >= COLUMNS) begin
              phase = PH_STB_HIGH;
            end else begin
              column = column + 1;
              phase  = PH_DATA;
            end
          end
        end
        PH_STB_HIGH: begin
          pins.stb = 1'b1;
          wait_cnt = clock_wait;
          phase    = PH_STB_LOW;
        end
        PH_STB_LOW: begin
          if (!hold_wait()) begin
            pins.stb = 1'b0;
            wait_cnt = clock_wait;
            phase    = PH_OE_LOW;
          end
        end
        PH_OE_LOW: begin
          if (!hold_wait()) begin
            pins.oe_n = 1'b0;
            wait_cnt  = enable_wait;
            phase     = PH_OE_HIGH;
          end
        end
        default: begin
          if (!hold_wait()) begin
            pins.oe_n = 1'b1;
            if (int'(scan_row) + 1 >= SCAN_ROWS) begin
              scan_row = '0;
              done     = 1'b1;
            end else begin
              scan_row = scan_row + 1'b1;
            end
            phase = PH_ADDR;
          end
        end
      endcase
      return done;
    endfunction

    function void note_input(logic op, logic [ROW_IDX_W-1:0] row,
                             logic [DATA_W-1:0] r, logic [DATA_W-1:0] g,
                             logic [DATA_W-1:0] b);
      pin_result_t res;
      res.done = 1'b0;
      if (op == OP_STORE) begin
        stores++;
        if (row < PANEL_ROWS) begin
          red_mem[row]   = r;
          green_mem[row] = g;
          blue_mem[row]  = b;
        end
      end else begin
        ticks++;
        res.done = advance_scan();
        if (res.done) frames++;
      end
      res.pins = pins;
      pending_pins.push_back(res);
    endfunction

    function void compare_field(string what, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch in %s at result %0d: expected %0d, got %0d",
                   what, checked, want, got);
      end
    endfunction

    function void check_result(pin_result_t got);
      pin_result_t want;
      if (pending_pins.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word with nothing outstanding at result %0d", checked);
      end else begin
        want = pending_pins.pop_front();
        compare_field("row_address", want.pins.addr, got.pins.addr);
        compare_field("pixel_clock", 4'(want.pins.clk), 4'(got.pins.clk));
        compare_field("strobe_res", 4'(want.pins.stb), 4'(got.pins.stb));
        compare_field("output_enable_n", 4'(want.pins.oe_n), 4'(got.pins.oe_n));
        compare_field("red_upper", 4'(want.pins.ru), 4'(got.pins.ru));
        compare_field("red_lower", 4'(want.pins.rl), 4'(got.pins.rl));
        compare_field("green_upper", 4'(want.pins.gu), 4'(got.pins.gu));
        compare_field("green_lower", 4'(want.pins.gl), 4'(got.pins.gl));
        compare_field("blue_upper", 4'(want.pins.bu), 4'(got.pins.bu));
        compare_field("blue_lower", 4'(want.pins.bl), 4'(got.pins.bl));
        compare_field("frame_done", 4'(want.done), 4'(got.done));
      end
      checked++;
    endfunction
  endclass

  pin_scoreboard sb;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin : monitor
    pin_result_t got;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        words_accepted++;
        sb.note_input(in_operation, in_row_index, in_red_bits, in_green_bits, in_blue_bits);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        got.pins.addr = out_row_address;
        got.pins.clk  = out_pixel_clock;
        got.pins.stb  = out_strobe_res;
        got.pins.oe_n = out_output_enable_n;
        got.pins.ru   = out_red_upper;
        got.pins.rl   = out_red_lower;
        got.pins.gu   = out_green_upper;
        got.pins.gl   = out_green_lower;
        got.pins.bu   = out_blue_upper;
        got.pins.bl   = out_blue_lower;
        got.done      = out_frame_done;
        sb.check_result(got);
      end
    end
  end

  // result side stall pattern, with one long hold-off
  initial begin : receiver
    int seg_left;
    int mode;
    int held;
    seg_left  = 0;
    mode      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && words_accepted >= HOLD_AT) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_LEN; held++) @(negedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 40);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // offer one word and hold it until taken
  task automatic send_word(input logic op, input logic [ROW_IDX_W-1:0] row,
                           input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] g,
                           input logic [DATA_W-1:0] b);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_row_index  <= row;
    in_red_bits   <= r;
    in_green_bits <= g;
    in_blue_bits  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WAIT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // bursts of random words, mostly ticks, with random gaps
  task automatic random_phase(input int count, input int tick_pct);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < count) begin
        send_word(($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_STORE,
                  4'($urandom_range(0, 15)), $urandom(), $urandom(), $urandom());
        sent++;
        burst--;
      end
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 20);
      endcase
      idle_cycles(gap);
    end
  endtask

  initial begin
    sb             = new();
    words_accepted = 0;
    reg_writes     = 0;
    long_hold_done = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_STORE;
    in_row_index   = '0;
    in_red_bits    = '0;
    in_green_bits  = '0;
    in_blue_bits   = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_CLOCK_WAIT;
    cfg_wdata      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset timing, pin levels after reset, edge patterns, live store
    send_word(OP_TICK, 4'd0, '0, '0, '0);
    send_word(OP_STORE, 4'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA);
    send_word(OP_STORE, 4'd8, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555);
    send_word(OP_STORE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_STORE, 4'd7, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_FFFF);
    repeat (12) send_word(OP_TICK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    idle_cycles(3);
    send_word(OP_STORE, 4'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    repeat (4) send_word(OP_TICK, 4'd0, '0, '0, '0);

    // fastest timing; long enough to step through most of the scan rows
    drain();
    write_reg(REG_CLOCK_WAIT, 16'd0);
    write_reg(REG_ENABLE_WAIT, 16'd0);
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h1234);
    random_phase(330, 95);
    drain();
    random_phase(280, 95);

    // short waits
    drain();
    write_reg(REG_CLOCK_WAIT, 16'd1);
    write_reg(REG_ENABLE_WAIT, 16'd3);
    random_phase(50, 85);

    // longest waits
    drain();
    write_reg(REG_CLOCK_WAIT, 16'hFFFF);
    write_reg(REG_ENABLE_WAIT, 16'hFFFF);
    random_phase(25, 80);

    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d words: %0d ticks, %0d row stores, %0d full frames scanned",
             words_accepted, sb.ticks, sb.stores, sb.frames);
    $display("%0d register writes over four timing settings, %0d results checked, %0d errors",
             reg_writes, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rmsd_pkg.sv
design/rmsd_frame_store.sv
design/rmsd_sequencer.sv
design/rgb_matrix_scan_driver.sv
sim/rgb_matrix_scan_driver_tb.sv
